@@ rtl/u2e_pkg.sv @@
`default_nettype none
package u2e_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int CpW    = 21;
  localparam int StepW  = 4;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChUpperU    = 8'h55;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] LeadMin     = 8'hC0;

  // last step index of an escape: backslash, u/U, then 4 or 8 digits
  localparam logic [StepW-1:0] LastStepSmall = 4'd5;
  localparam logic [StepW-1:0] LastStepBig   = 4'd9;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_ESC  = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CpW-1:0]   data;     // plain char in low byte, or code point
    logic             partial;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? ChUpperA : ChLowerA;
      if (nib < 4'd10) hex_char = ChZero + {4'd0, nib};
      else hex_char = base + {4'd0, nib - 4'd10};
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/u2e_front.sv @@
`default_nettype none
module u2e_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  output u2e_pkg::cmd_t       cmd,
  output logic                cmd_wr
);

  logic [1:0]                 followers_left;
  logic [u2e_pkg::CpW-1:0]    code_point;
  logic [u2e_pkg::CpW-1:0]    cp_shifted;

  assign cp_shifted = {code_point[u2e_pkg::CpW-7:0], in_byte[5:0]};

  always_comb begin
    cmd_wr      = 1'b0;
    cmd.kind    = u2e_pkg::CMD_CHAR;
    cmd.data    = {{(u2e_pkg::CpW-8){1'b0}}, in_byte};
    cmd.partial = 1'b0;
    if (in_byte == 8'd0) begin
      cmd_wr      = accept;
      cmd.kind    = u2e_pkg::CMD_END;
      cmd.partial = (followers_left != 2'd0);
    end else if (followers_left != 2'd0) begin
      cmd_wr   = accept && (followers_left == 2'd1);
      cmd.kind = u2e_pkg::CMD_ESC;
      cmd.data = cp_shifted;
    end else if (in_byte < u2e_pkg::LeadMin) begin
      cmd_wr = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      followers_left <= 2'd0;
      code_point     <= '0;
    end else if (accept) begin
      if (in_byte == 8'd0) begin
        followers_left <= 2'd0;
        code_point     <= '0;
      end else if (followers_left != 2'd0) begin
        followers_left <= followers_left - 2'd1;
        code_point     <= (followers_left == 2'd1) ? '0 : cp_shifted;
      end else if (in_byte >= u2e_pkg::LeadMin) begin
        if (in_byte < 8'hE0) begin
          followers_left <= 2'd1;
          code_point     <= {{(u2e_pkg::CpW-5){1'b0}}, in_byte[4:0]};
        end else if (in_byte < 8'hF0) begin
          followers_left <= 2'd2;
          code_point     <= {{(u2e_pkg::CpW-4){1'b0}}, in_byte[3:0]};
        end else begin
          followers_left <= 2'd3;
          code_point     <= {{(u2e_pkg::CpW-3){1'b0}}, in_byte[2:0]};
        end
      end else begin
        code_point <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/u2e_queue.sv @@
`default_nettype none
module u2e_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  u2e_pkg::cmd_t       wr_cmd,
  input  wire logic           rd,
  output u2e_pkg::cmd_t       rd_cmd,
  output logic                q_full,
  output logic                q_empty
);

  u2e_pkg::cmd_t              slots [u2e_pkg::QDepth];
  logic [u2e_pkg::QAw-1:0]    wr_ptr;
  logic [u2e_pkg::QAw-1:0]    rd_ptr;
  logic [u2e_pkg::QAw:0]      count;

  assign q_full  = (count == (u2e_pkg::QAw+1)'(u2e_pkg::QDepth));
  assign q_empty = (count == '0);
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/u2e_back.sv @@
`default_nettype none
module u2e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           hex_uppercase,
  input  u2e_pkg::cmd_t       cmd,
  input  wire logic           cmd_avail,
  output logic                cmd_rd,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          out_char,
  output logic                run_last,
  output logic                is_end,
  output logic                partial_dropped
);

  logic                       out_valid;
  logic [u2e_pkg::StepW-1:0]  step;
  logic [u2e_pkg::StepW-1:0]  last_step;
  logic [u2e_pkg::StepW-1:0]  nib_idx;
  logic [31:0]                cp_wide;
  logic [31:0]                cp_sh;
  logic                       big;
  logic                       load;
  logic [7:0]                 ch;
  logic                       ch_end;

  assign empty   = !out_valid;
  assign load    = cmd_avail && (!out_valid || pop);
  assign big     = |cmd.data[u2e_pkg::CpW-1:16];
  assign cp_wide = {{(32-u2e_pkg::CpW){1'b0}}, cmd.data};
  assign nib_idx = last_step - step;
  assign cp_sh   = cp_wide >> {nib_idx[2:0], 2'b00};

  always_comb begin
    last_step = '0;
    ch        = cmd.data[7:0];
    ch_end    = 1'b0;
    unique case (cmd.kind)
      u2e_pkg::CMD_CHAR: ch = cmd.data[7:0];
      u2e_pkg::CMD_END: begin
        ch     = 8'd0;
        ch_end = 1'b1;
      end
      u2e_pkg::CMD_ESC: begin
        last_step = big ? u2e_pkg::LastStepBig : u2e_pkg::LastStepSmall;
        if (step == 4'd0) ch = u2e_pkg::ChBackslash;
        else if (step == 4'd1) ch = big ? u2e_pkg::ChUpperU : u2e_pkg::ChLowerU;
        else ch = u2e_pkg::hex_char(cp_sh[3:0], hex_uppercase);
      end
      default: ch = 8'd0;
    endcase
  end

  assign cmd_rd = load && (step == last_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) step <= (step == last_step) ? '0 : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char        <= ch;
      run_last        <= (step == last_step);
      is_end          <= ch_end;
      partial_dropped <= ch_end && cmd.partial;
    end
  end

endmodule
`default_nettype wire

@@ rtl/utf8_to_unicode_escape.sv @@
// UTF-8 to backslash-u escape encoder.
// Input side is a queue: drive in_byte and push; the byte is taken at an edge
// where push is high and full is low. Zero ends a string.
// Output side is a queue: while empty is low the oldest result sits on
// out_char/run_last/is_end/partial_dropped; pop at an edge with empty low
// takes it. run_last marks the last char produced by one input byte.
// Config: cfg_data[0] is hex_uppercase, written when cfg_valid is high
// (cfg_ready is always high); write only while the block is idle.
// A byte that produces output is written into the command queue and then
// into the output register. Lead bytes and non-final followers produce
// nothing.
// Throughput: one input byte per cycle while full is low and one result per
// cycle while pop is high. A plain byte yields one char, a finished sequence
// 6 or 10 (\uXXXX or \UXXXXXXXX), emitted by the single output register; a
// 4-entry command queue between the decoder and the emitter absorbs bursts.
// When pop is held low, results wait and full rises once the queue fills.
// Reset empties the queue and output, clears any partial sequence and sets
// hex_uppercase to 1.
`default_nettype none
module utf8_to_unicode_escape (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_char,
  output logic             run_last,
  output logic             is_end,
  output logic             partial_dropped,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic            hex_uppercase;
  logic            accept;
  logic            cmd_wr;
  logic            cmd_rd;
  logic            q_empty;
  u2e_pkg::cmd_t   wr_cmd;
  u2e_pkg::cmd_t   rd_cmd;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) hex_uppercase <= 1'b1;
    else if (cfg_valid && cfg_ready) hex_uppercase <= cfg_data;
  end

  u2e_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .cmd     (wr_cmd),
    .cmd_wr  (cmd_wr)
  );

  u2e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_wr),
    .wr_cmd  (wr_cmd),
    .rd      (cmd_rd),
    .rd_cmd  (rd_cmd),
    .q_full  (full),
    .q_empty (q_empty)
  );

  u2e_back u_back (
    .clk             (clk),
    .rst             (rst),
    .hex_uppercase   (hex_uppercase),
    .cmd             (rd_cmd),
    .cmd_avail       (!q_empty),
    .cmd_rd          (cmd_rd),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .run_last        (run_last),
    .is_end          (is_end),
    .partial_dropped (partial_dropped)
  );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandBytesPerPhase = 120;
  localparam int HoldCycles        = 80;
  localparam int SettleCycles      = 12;
  localparam int CycleLimit        = 200000;
  localparam int MaxPrinted        = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       end_mark;
    logic       part;
  } esc_out_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    esc_out_t   want;
  } dir_row_t;

  localparam esc_out_t NoWant = '0;
  localparam int NumRows = 22;

  // typed rows (plain chars, stray continuations, end marks) give their output; others are predicted
  localparam dir_row_t DirRows [NumRows] = '{
    '{8'h41, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'h80, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b0}},
    '{8'hBF, 1'b1, '{8'hBF, 1'b1, 1'b0, 1'b0}},
    '{8'hC3, 1'b0, NoWant}, '{8'hA9, 1'b0, NoWant},
    '{8'hDF, 1'b0, NoWant}, '{8'hBF, 1'b0, NoWant},
    '{8'hE2, 1'b0, NoWant}, '{8'h82, 1'b0, NoWant}, '{8'hAC, 1'b0, NoWant},
    '{8'hF0, 1'b0, NoWant}, '{8'h9F, 1'b0, NoWant}, '{8'h98, 1'b0, NoWant},
    '{8'h80, 1'b0, NoWant},
    // 0xFF lead, largest code point
    '{8'hFF, 1'b0, NoWant}, '{8'hBF, 1'b0, NoWant}, '{8'hBF, 1'b0, NoWant},
    '{8'hBF, 1'b0, NoWant},
    // unchecked follower, then end inside the sequence
    '{8'hE0, 1'b0, NoWant}, '{8'h41, 1'b0, NoWant},
    '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_data = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_char;
  logic       run_last;
  logic       is_end;
  logic       partial_dropped;
  logic       cfg_ready;

  utf8_to_unicode_escape dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .empty(empty),
    .pop(pop),
    .out_char(out_char),
    .run_last(run_last),
    .is_end(is_end),
    .partial_dropped(partial_dropped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder state mirror
  logic [1:0]  seq_left = 2'd0;
  logic [20:0] cp_acc = '0;
  logic        hex_upper = 1'b1;

  esc_out_t pending_out[$];
  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int hold_reqs = 0;
  bit idle_on = 1'b1;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_out.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (errors < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    if (nib < 4'd10) return u2e_pkg::ChZero + {4'd0, nib};
    return (hex_upper ? u2e_pkg::ChUpperA : u2e_pkg::ChLowerA) + {4'd0, nib} - 8'd10;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input bit keep);
    esc_out_t outs[$];
    logic [31:0] cpw;
    int nd;
    if (b == 8'h00) begin
      outs.push_back('{8'h00, 1'b1, 1'b1, seq_left != 2'd0});
      seq_left = 2'd0;
      cp_acc = '0;
    end else if (seq_left != 2'd0) begin
      cp_acc = {cp_acc[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        cpw = {11'd0, cp_acc};
        cp_acc = '0;
        nd = (cpw >= 32'h10000) ? 8 : 4;
        outs.push_back('{u2e_pkg::ChBackslash, 1'b0, 1'b0, 1'b0});
        outs.push_back('{(nd == 8) ? u2e_pkg::ChUpperU : u2e_pkg::ChLowerU,
                         1'b0, 1'b0, 1'b0});
        for (int d = nd - 1; d >= 0; d--)
          outs.push_back('{digit_char(cpw[4*d +: 4]), d == 0, 1'b0, 1'b0});
      end
    end else if (b >= u2e_pkg::LeadMin) begin
      if (b < 8'hE0) begin
        seq_left = 2'd1;
        cp_acc = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        seq_left = 2'd2;
        cp_acc = {17'd0, b[3:0]};
      end else begin
        seq_left = 2'd3;
        cp_acc = {18'd0, b[2:0]};
      end
    end else begin
      cp_acc = '0;
      outs.push_back('{b, 1'b1, 1'b0, 1'b0});
    end
    if (keep) pending_out = {pending_out, outs};
  endtask

  // offer one byte until accepted, then log what it should produce
  task automatic feed(input logic [7:0] b, input bit typed, input esc_out_t want);
    while (idle_on && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
    predict_byte(b, !typed);
    if (typed) pending_out.push_back(want);
  endtask

  task automatic write_case(input logic upper);
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    // a trailing lead byte yields nothing, give it time to settle
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= upper;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hex_upper = upper;
  endtask

  function automatic logic [7:0] follower_byte();
    if ($urandom_range(99) < 85) return {2'b10, 6'($urandom_range(63))};
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_random(input int count);
    int stop_at;
    int kind;
    int nf;
    logic [7:0] lead;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        feed(8'($urandom_range(1, 127)), 1'b0, NoWant);
      end else if (kind < 33) begin
        feed(8'($urandom_range(8'h80, 8'hBF)), 1'b0, NoWant);
      end else if (kind < 84 && kind >= 78) begin
        feed(8'h00, 1'b0, NoWant);
      end else if (kind >= 84 && kind < 92) begin
        // sequence start with fewer followers than it needs, cut short by an end mark
        lead = 8'($urandom_range(8'hC0, 8'hFF));
        nf = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
        feed(lead, 1'b0, NoWant);
        repeat ($urandom_range(nf - 1)) feed(follower_byte(), 1'b0, NoWant);
        feed(8'h00, 1'b0, NoWant);
      end else if (kind >= 92) begin
        feed(8'($urandom_range(255)), 1'b0, NoWant);
      end else begin
        if (kind < 48) lead = 8'($urandom_range(8'hC0, 8'hDF));
        else if (kind < 63) lead = 8'($urandom_range(8'hE0, 8'hEF));
        else lead = 8'($urandom_range(8'hF0, 8'hFF));
        nf = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
        feed(lead, 1'b0, NoWant);
        repeat (nf) feed(follower_byte(), 1'b0, NoWant);
      end
    end
  endtask

  initial begin : drain
    int hold_left;
    int seen;
    esc_out_t got;
    esc_out_t want;
    hold_left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{out_char, run_last, is_end, partial_dropped};
        results_seen++;
        if (pending_out.size() == 0) begin
          flag_mismatch($sformatf("unexpected item char=%h last=%b end=%b part=%b",
                                  got.ch, got.last, got.end_mark, got.part));
        end else begin
          want = pending_out.pop_front();
          if (got !== want)
            flag_mismatch($sformatf(
                "char=%h/%h last=%b/%b end=%b/%b part=%b/%b (got/want)",
                got.ch, want.ch, got.last, want.last, got.end_mark, want.end_mark,
                got.part, want.part));
        end
      end
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(idle_on && $urandom_range(99) < 17);
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++)
      feed(DirRows[i].b, DirRows[i].typed, DirRows[i].want);

    write_case(1'b0);
    hold_reqs++;  // output side stalls while input keeps coming
    send_random(RandBytesPerPhase);

    write_case(1'b1);
    idle_on = 1'b0;
    send_random(RandBytesPerPhase);
    idle_on = 1'b1;

    write_case(1'b0);
    send_random(RandBytesPerPhase);

    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d bytes and checked %0d output items in %0d cycles,", bytes_sent,
             results_seen, cycles);
    $display("covering both hex cases, partial sequences, a full stall and idle-free traffic.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/u2e_pkg.sv
rtl/u2e_front.sv
rtl/u2e_queue.sv
rtl/u2e_back.sv
rtl/utf8_to_unicode_escape.sv
verif/testbench.sv
